// ----- design/assert_macros.svh -----
// Assertion macros used by the top level of the vertex deduplication block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at every rising clock edge outside reset.
`define TVD_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checks that a condition is followed in the next cycle by another.
`define TVD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TVD_ASSERT(lbl, clk, rstn, prop, msg)
`define TVD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- design/tvd_pkg.sv -----
// Package with the field widths and constants of the vertex deduplication block.
package tvd_pkg;

	localparam int unsigned MAX_VERTICES_DEF = 1024;
	localparam int unsigned COORD_W          = 32;
	localparam int unsigned INDEX_W          = 10;
	localparam int unsigned CORNER_W         = 2;
	localparam int unsigned S_TDATA_W        = 3 * COORD_W;
	localparam int unsigned M_TDATA_W        = 16;

	localparam logic [CORNER_W-1:0] CORNER_FIRST = 2'd0;
	localparam logic [CORNER_W-1:0] CORNER_LAST  = 2'd2;

	// Odd multiplier for the hash; spreads the folded key over the top bits.
	localparam logic [COORD_W-1:0] HASH_MULT = 32'h9E37_79B1;

endpackage

// ----- design/triangle_vertex_dedup.sv -----
// Top level of the vertex deduplication block: hashed lookup table with a probe sequencer.
//
//  channel  | dir | fields (lowest bits first)
//  ---------+-----+-----------------------------------------------------------
//  s_*      | in  | tdata: coord_x, coord_y, coord_z
//  m_*      | out | tdata: vertex_index, is_new, corner, table_full, 2 zero bits
//
// Each item passes the states HASH, PROBE and CMP, with PROBE and CMP repeated for every
// further hash slot probed (one at best); each probe is one read of the slot memory.
// s_tready returns with the result, so the next item is taken only once that is loaded.
// After reset a clearing pass marks all 2 * 2**$clog2(MAX_VERTICES) slots empty,
// one slot a cycle, and s_tready stays low meanwhile.
// One item is in work at a time; a finished result waits in the output register, and
// the next item is taken while it waits, but its result is held until the first is taken.
`include "assert_macros.svh"

module triangle_vertex_dedup
	import tvd_pkg::*;
#(
	parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // coord_x, coord_y, coord_z
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // vertex_index, is_new, corner, table_full
);

	localparam int unsigned IDX_W   = $clog2(MAX_VERTICES);
	localparam int unsigned CNT_W   = $clog2(MAX_VERTICES + 1);
	localparam int unsigned HT_AW   = IDX_W + 1;
	localparam int unsigned HT_D    = 2 ** HT_AW;
	localparam int unsigned ENT_W   = 1 + 3 * COORD_W + IDX_W;
	localparam int unsigned PAD_W   = IDX_W + INDEX_W;
	localparam int unsigned M_PAD_W = M_TDATA_W - INDEX_W - CORNER_W - 2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_CMP,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [HT_AW-1:0]     clr_q;
	logic [HT_AW-1:0]     addr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CORNER_W-1:0]  corner_q;
	logic [COORD_W-1:0]   x_q, y_q, z_q;
	logic [IDX_W-1:0]     res_idx_q;
	logic                 res_new_q;
	logic                 res_full_q;
	logic                 m_tvalid_q;
	logic [INDEX_W-1:0]   out_idx_q;
	logic                 out_new_q;
	logic [CORNER_W-1:0]  out_corner_q;
	logic                 out_full_q;

	// Slot memory: {valid, z, y, x, index}.
	logic [ENT_W-1:0]     mem [HT_D];
	logic [ENT_W-1:0]     rd_q;
	logic                 we;
	logic [HT_AW-1:0]     wa;
	logic [ENT_W-1:0]     wd;

	logic [COORD_W-1:0]   key_fold;
	logic [COORD_W-1:0]   key_prod;
	logic                 rd_valid;
	logic                 rd_match;
	logic                 room;
	logic                 insert;
	logic                 out_load;
	logic [PAD_W-1:0]     idx_wide;

	assign key_fold = x_q ^ {y_q[20:0], y_q[31:21]} ^ {z_q[9:0], z_q[31:10]};
	assign key_prod = key_fold * HASH_MULT;

	assign rd_valid = rd_q[ENT_W-1];
	assign rd_match = (rd_q[IDX_W +: COORD_W] == x_q)
		&& (rd_q[IDX_W + COORD_W +: COORD_W] == y_q)
		&& (rd_q[IDX_W + 2 * COORD_W +: COORD_W] == z_q);
	assign room     = (cnt_q < CNT_W'(MAX_VERTICES));
	assign insert   = (state_q == ST_CMP) && !rd_valid && room;
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	assign idx_wide = {{INDEX_W{1'b0}}, res_idx_q};

	always_comb begin
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
			wa = clr_q;
			wd = '0;
		end else begin
			we = insert;
			wa = addr_q;
			wd = {1'b1, z_q, y_q, x_q, cnt_q[IDX_W-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			cnt_q        <= '0;
			corner_q     <= CORNER_FIRST;
			m_tvalid_q   <= 1'b0;
			addr_q       <= '0;
			x_q          <= '0;
			y_q          <= '0;
			z_q          <= '0;
			res_idx_q    <= '0;
			res_new_q    <= 1'b0;
			res_full_q   <= 1'b0;
			out_idx_q    <= '0;
			out_new_q    <= 1'b0;
			out_corner_q <= CORNER_FIRST;
			out_full_q   <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {HT_AW{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						x_q     <= s_tdata[0 +: COORD_W];
						y_q     <= s_tdata[COORD_W +: COORD_W];
						z_q     <= s_tdata[2 * COORD_W +: COORD_W];
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					addr_q  <= key_prod[COORD_W-1 -: HT_AW];
					state_q <= ST_PROBE;
				end
				ST_PROBE: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (rd_valid && rd_match) begin
						res_idx_q  <= rd_q[IDX_W-1:0];
						res_new_q  <= 1'b0;
						res_full_q <= 1'b0;
						state_q    <= ST_DONE;
					end else if (!rd_valid) begin
						if (room) begin
							res_idx_q  <= cnt_q[IDX_W-1:0];
							res_new_q  <= 1'b1;
							res_full_q <= 1'b0;
							cnt_q      <= cnt_q + 1'b1;
						end else begin
							res_idx_q  <= '0;
							res_new_q  <= 1'b0;
							res_full_q <= 1'b1;
						end
						state_q <= ST_DONE;
					end else begin
						// Occupied by another vertex: try the next slot.
						addr_q  <= addr_q + 1'b1;
						state_q <= ST_PROBE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						m_tvalid_q   <= 1'b1;
						out_idx_q    <= idx_wide[INDEX_W-1:0];
						out_new_q    <= res_new_q;
						out_full_q   <= res_full_q;
						out_corner_q <= corner_q;
						corner_q     <= (corner_q >= CORNER_LAST) ? CORNER_FIRST
							: corner_q + 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, out_full_q, out_corner_q, out_new_q, out_idx_q};

	`TVD_ASSERT(a_count_bound, clk, arst_n, cnt_q <= CNT_W'(MAX_VERTICES), "count too high")
	`TVD_ASSERT_NEXT(a_insert_counts, clk, arst_n, insert, cnt_q == $past(cnt_q) + 1'b1, "no count")
	`TVD_ASSERT(a_new_or_full, clk, arst_n, !(m_tvalid_q && out_new_q && out_full_q), "new and full")
	`TVD_ASSERT_NEXT(a_load_shows, clk, arst_n, out_load, m_tvalid_q && (state_q == ST_IDLE), "no show")

endmodule

// ----- test/tb_triangle_vertex_dedup.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the vertex deduplication block with a scoreboard class.
module tb_triangle_vertex_dedup
	import tvd_pkg::*;
();

	localparam int unsigned TABLE_SIZE   = MAX_VERTICES_DEF;
	localparam int unsigned LIMIT_CYCLES = 1_000_000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned IDLE_PCT     = 9;
	localparam int unsigned RANDOM_ITEMS = 1150;
	localparam int unsigned AFTER_FULL   = 70;

	localparam logic [COORD_W-1:0] POS_ZERO = 32'h0000_0000;
	localparam logic [COORD_W-1:0] NEG_ZERO = 32'h8000_0000;
	localparam logic [COORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [COORD_W-1:0] POS_INF  = 32'h7F80_0000;
	localparam logic [COORD_W-1:0] NEG_INF  = 32'hFF80_0000;
	localparam logic [COORD_W-1:0] QNAN     = 32'h7FC0_0000;
	localparam logic [COORD_W-1:0] QNAN_PL  = 32'h7FC0_0001;
	localparam logic [COORD_W-1:0] NEG_QNAN = 32'hFFC0_0000;
	localparam logic [COORD_W-1:0] MAX_NORM = 32'h7F7F_FFFF;
	localparam logic [COORD_W-1:0] ONE      = 32'h3F80_0000;
	localparam logic [COORD_W-1:0] TWO      = 32'h4000_0000;
	localparam logic [COORD_W-1:0] THREE    = 32'h4040_0000;
	localparam logic [COORD_W-1:0] ONE_ULP  = 32'h3F80_0001;
	localparam logic [COORD_W-1:0] CHECKER  = 32'hAAAA_AAAA;
	localparam logic [COORD_W-1:0] CHECKER2 = 32'h5555_5555;

	localparam logic [COORD_W-1:0] SPECIAL_COORDS [8] = '{
		POS_ZERO, NEG_ZERO, ALL_ONES, POS_INF, NEG_INF, QNAN, NEG_QNAN, MAX_NORM
	};

	// Each entry is {z, y, x}; covers signed zeros, NaN repeats and single-axis differences.
	localparam logic [S_TDATA_W-1:0] DIRECTED [18] = '{
		{POS_ZERO, POS_ZERO, POS_ZERO},
		{ALL_ONES, ALL_ONES, ALL_ONES},
		{POS_ZERO, POS_ZERO, NEG_ZERO},
		{POS_ZERO, NEG_ZERO, POS_ZERO},
		{NEG_ZERO, POS_ZERO, POS_ZERO},
		{POS_ZERO, POS_ZERO, POS_ZERO},
		{NEG_QNAN, QNAN_PL, QNAN},
		{NEG_QNAN, QNAN_PL, QNAN},
		{MAX_NORM, NEG_INF, POS_INF},
		{THREE, TWO, ONE},
		{THREE, TWO, ONE_ULP},
		{THREE, ONE_ULP, ONE},
		{ONE_ULP, TWO, ONE},
		{THREE, TWO, ONE},
		{ALL_ONES, ALL_ONES, ALL_ONES},
		{CHECKER, CHECKER2, CHECKER},
		{CHECKER2, CHECKER, CHECKER2},
		{CHECKER, CHECKER2, CHECKER}
	};

	typedef struct packed {
		logic [1:0]          pad;
		logic                table_full;
		logic [CORNER_W-1:0] corner;
		logic                is_new;
		logic [INDEX_W-1:0]  index;
	} dedup_result_t;

	class vertex_scoreboard;
		int unsigned   slot_of [logic [S_TDATA_W-1:0]];
		int unsigned   fill;
		logic [CORNER_W-1:0] corner;
		dedup_result_t pending [$];
		int unsigned   errors;

		function new();
			fill   = 0;
			corner = CORNER_FIRST;
			errors = 0;
		endfunction

		function void flag(string what, int unsigned want, int unsigned got);
			errors++;
			if (errors <= 10)
				$display("mismatch in %s: expected %0d, got %0d", what, want, got);
		endfunction

		// Looks the vertex up in the distinct table and queues the result it must produce.
		function void note_vertex(logic [S_TDATA_W-1:0] key);
			dedup_result_t r;
			r = '0;
			r.corner = corner;
			if (slot_of.exists(key)) begin
				r.index = INDEX_W'(slot_of[key]);
			end else if (fill < TABLE_SIZE) begin
				slot_of[key] = fill;
				r.index = INDEX_W'(fill);
				r.is_new = 1'b1;
				fill++;
			end else begin
				r.table_full = 1'b1;
			end
			corner = (corner >= CORNER_LAST) ? CORNER_FIRST : corner + 1'b1;
			pending = {pending, r};
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] word);
			dedup_result_t got;
			dedup_result_t want;
			got = dedup_result_t'(word);
			if (pending.size() == 0) begin
				flag("unexpected result, vertex_index", 0, got.index);
				return;
			end
			want = pending.pop_front();
			if (got.index !== want.index)
				flag("vertex_index", want.index, got.index);
			if (got.is_new !== want.is_new)
				flag("is_new", want.is_new, got.is_new);
			if (got.corner !== want.corner)
				flag("corner", want.corner, got.corner);
			if (got.table_full !== want.table_full)
				flag("table_full", want.table_full, got.table_full);
			if (got.pad !== want.pad)
				flag("padding bits", want.pad, got.pad);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // coord_x, coord_y, coord_z
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // vertex_index, is_new, corner, table_full

	vertex_scoreboard sb = new();
	int unsigned      n_in = 0;
	int unsigned      cycles = 0;
	int unsigned      hold_left = 0;
	logic             held_once = 1'b0;
	logic             calm;

	// Neither side idles while this window of transfers is under way.
	assign calm = (n_in >= 300) && (n_in < 500);

	triangle_vertex_dedup dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("triangle_vertex_dedup regression: fail");
			$finish;
		end
	end

	// Handshakes are sampled mid-cycle, where every signal has settled; the transfer
	// then takes place at the following rising edge.
	always @(negedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			sb.note_vertex(s_tdata);
			n_in <= n_in + 1;
		end
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// Receiver: random stalls, plus one long hold-off so that the block backs up.
	always @(posedge clk) begin
		if (!held_once && n_in >= 600) begin
			held_once <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic send_vertex(input logic [S_TDATA_W-1:0] v);
		logic took;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
	endtask

	function automatic logic [COORD_W-1:0] rand_coord();
		if ($urandom_range(15) == 0)
			return SPECIAL_COORDS[$urandom_range(7)];
		return $urandom();
	endfunction

	initial begin
		logic [S_TDATA_W-1:0] pool [$];
		logic [S_TDATA_W-1:0] v;
		int unsigned          sent;
		int unsigned          post_full;
		int unsigned          pick;
		int unsigned          repeat_pct;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			send_vertex(DIRECTED[i]);
			pool = {pool, DIRECTED[i]};
		end

		// Mesh-like stream: mostly fresh vertices until the table fills, then about half
		// shared corners, mixed with misses that hit the full table.
		sent = 0;
		post_full = 0;
		while (sent < RANDOM_ITEMS || sb.fill < TABLE_SIZE || post_full < AFTER_FULL) begin
			repeat_pct = (sb.fill < TABLE_SIZE) ? 5 : 50;
			pick = $urandom_range(99);
			if (pick < repeat_pct) begin
				v = pool[$urandom_range(pool.size() - 1)];
			end else if (pick < repeat_pct + 4) begin
				v = pool[$urandom_range(pool.size() - 1)];
				v[$urandom_range(S_TDATA_W - 1)] ^= 1'b1;
			end else begin
				v = {rand_coord(), rand_coord(), rand_coord()};
			end
			send_vertex(v);
			pool = {pool, v};
			sent++;
			if (sb.fill >= TABLE_SIZE)
				post_full++;
		end
		s_tvalid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("triangle_vertex_dedup regression: pass");
		end else begin
			$display("triangle_vertex_dedup regression: fail");
		end
		$finish;
	end

endmodule
